[rtl/alfe_pkg.sv]
// Shared types and constants for the addressable LED frame encoder.
// No dependencies; every other file imports this package.
package alfe_pkg;

    // Pixel format and defaults
    localparam int BITS_PER_PIXEL       = 24;
    localparam int DEFAULT_PIXEL_COUNT  = 8;
    localparam int BIT_IDX_W            = 5;
    localparam logic [BIT_IDX_W-1:0] BIT_TOP = BIT_IDX_W'(BITS_PER_PIXEL - 1);

    // Register reset values
    localparam logic [7:0] RST_DUTY_ONE  = 8'd67;
    localparam logic [7:0] RST_DUTY_ZERO = 8'd33;
    localparam logic [7:0] RST_LATCH     = 8'd50;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DUTY_ONE  = 2'd0,
        CFG_DUTY_ZERO = 2'd1,
        CFG_LATCH     = 2'd2
    } t_cfg_idx;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_WRITE_PIXEL = 2'd0,
        KIND_WRITE_ALL   = 2'd1,
        KIND_START       = 2'd2,
        KIND_TICK        = 2'd3
    } t_kind;

    // Frame sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_LATCH = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] duty;
        logic       last;
    } t_out_item;

    // Pixel store request, sequencer to store; address sized for the largest store
    typedef struct packed {
        logic                      wr_en;
        logic                      wr_all;
        logic [7:0]                wr_addr;
        logic [BITS_PER_PIXEL-1:0] wr_color;
        logic                      rd_en;
        logic [7:0]                rd_addr;
    } t_store_req;

endpackage

[rtl/alfe_ifs.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on alfe_pkg for the payload structs.
interface alfe_in_if import alfe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface alfe_out_if import alfe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/alfe_pixel_store.sv]
// Pixel color memory with per-entry valid bits and a fill color for write-all.
// Depends on alfe_pkg (t_store_req, BITS_PER_PIXEL).
module alfe_pixel_store import alfe_pkg::*; #(
    parameter int PIXEL_COUNT = DEFAULT_PIXEL_COUNT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_store_req                i_req,
    output logic [BITS_PER_PIXEL-1:0] o_color
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    logic [BITS_PER_PIXEL-1:0] r_mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0]    r_valid;
    logic [BITS_PER_PIXEL-1:0] r_fill;
    logic [BITS_PER_PIXEL-1:0] r_rd;
    logic [BITS_PER_PIXEL-1:0] r_rd_fill;
    logic                      r_rd_hit;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;

    assign wr_addr = i_req.wr_addr[AW-1:0];
    assign rd_addr = i_req.rd_addr[AW-1:0];

    // Memory array: single write, single registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[wr_addr] <= i_req.wr_color;
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Valid bits and fill color; write-all drops every entry back to the fill color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
        end else if (i_req.wr_all) begin
            r_valid <= '0;
            r_fill  <= i_req.wr_color;
        end else if (i_req.wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Capture the resolve inputs in the same cycle as the memory read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_hit  <= r_valid[rd_addr];
            r_rd_fill <= r_fill;
        end
    end

    assign o_color = r_rd_hit ? r_rd : r_rd_fill;

endmodule

[rtl/addressable_led_frame_encoder_core.sv]
// Top level of the addressable LED frame encoder: config registers, frame
// sequencer and output stage. Depends on alfe_pkg, alfe_ifs and alfe_pixel_store.
//
//  Channel  | Dir | Handshake         | Payload
//  ---------+-----+-------------------+----------------------------------------
//  i_in     | in  | valid/ready       | kind, pixel_index, red, green, blue
//  o_out    | out | valid/ready       | duty, last (one item per active tick)
//  i_cfg_*  | in  | write enable only | index 0 duty_for_one, 1 zero, 2 latch
//
// One input item is accepted every cycle while the read stage is free or the
// output can advance; a tick's result passes through the registered read of the
// pixel memory and then the output register. Reset is synchronous: the pixel
// valid bits clear at once, so there is no clearing pass. A stalled output holds
// its item, and one more tick can wait in the read stage before input ready drops.
module addressable_led_frame_encoder_core import alfe_pkg::*; #(
    parameter int PIXEL_COUNT = DEFAULT_PIXEL_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alfe_in_if.sink    i_in,
    alfe_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [AW-1:0] PIX_LAST = AW'(PIXEL_COUNT - 1);

    logic [7:0]      r_duty_one;
    logic [7:0]      r_duty_zero;
    logic [7:0]      r_latch;
    t_phase          r_phase, n_phase;
    logic [AW-1:0]   r_pix, n_pix;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [7:0]      r_lat, n_lat;
    logic            r_s1v, n_s1v;
    logic            r_s1_data;
    logic            r_s1_last;
    logic [BIT_IDX_W-1:0] r_s1_bit;
    logic            r_ov;
    t_out_item       r_od;

    logic            en_out;
    logic            acc;
    logic            is_tick;
    logic            tick_emit;
    logic            emit_data;
    logic            emit_last;
    logic            lat_done;
    logic [7:0]      latch_eff;
    t_store_req      store_req;
    logic [BITS_PER_PIXEL-1:0] color;
    logic [7:0]      duty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_one  <= RST_DUTY_ONE;
            r_duty_zero <= RST_DUTY_ZERO;
            r_latch     <= RST_LATCH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DUTY_ONE:  r_duty_one  <= i_cfg_data;
                CFG_DUTY_ZERO: r_duty_zero <= i_cfg_data;
                CFG_LATCH:     r_latch     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake
    assign en_out      = !r_ov || o_out.ready;
    assign i_in.ready  = !r_s1v || en_out;
    assign acc         = i_in.valid && i_in.ready;
    assign is_tick     = acc && (i_in.data.kind == KIND_TICK);

    // Latch length: zero counts as one slot
    assign latch_eff = (r_latch == 8'd0) ? 8'd1 : r_latch;
    assign lat_done  = (r_lat >= (latch_eff - 8'd1));

    // Sequencer next state
    always_comb begin
        n_phase = r_phase;
        n_pix   = r_pix;
        n_bit   = r_bit;
        n_lat   = r_lat;
        if (acc && (i_in.data.kind == KIND_START)) begin
            n_phase = PH_DATA;
            n_pix   = '0;
            n_bit   = BIT_TOP;
            n_lat   = '0;
        end else if (is_tick) begin
            unique case (r_phase)
                PH_DATA: begin
                    if (r_bit == '0) begin
                        n_bit = BIT_TOP;
                        if (r_pix == PIX_LAST) begin
                            n_pix   = '0;
                            n_phase = PH_LATCH;
                        end else begin
                            n_pix = r_pix + AW'(1);
                        end
                    end else begin
                        n_bit = r_bit - BIT_IDX_W'(1);
                    end
                end
                PH_LATCH: begin
                    if (lat_done) begin
                        n_phase = PH_IDLE;
                        n_lat   = '0;
                    end else begin
                        n_lat = r_lat + 8'd1;
                    end
                end
                PH_IDLE: ;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Sequencer outputs and store request
    always_comb begin
        tick_emit = is_tick && (r_phase != PH_IDLE);
        emit_data = (r_phase == PH_DATA);
        emit_last = (r_phase == PH_LATCH) && lat_done;
        store_req.rd_en    = is_tick && (r_phase == PH_DATA);
        store_req.rd_addr  = 8'(r_pix);
        store_req.wr_en    = acc && (i_in.data.kind == KIND_WRITE_PIXEL)
                             && ({1'b0, i_in.data.pixel_index} < 9'(PIXEL_COUNT));
        store_req.wr_all   = acc && (i_in.data.kind == KIND_WRITE_ALL);
        store_req.wr_addr  = i_in.data.pixel_index;
        store_req.wr_color = {i_in.data.green, i_in.data.red, i_in.data.blue};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pix   <= '0;
            r_bit   <= BIT_TOP;
            r_lat   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pix   <= n_pix;
            r_bit   <= n_bit;
            r_lat   <= n_lat;
        end
    end

    alfe_pixel_store #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_color (color)
    );

    // Read stage: holds a tick while the memory read completes
    always_comb begin
        n_s1v = r_s1v;
        if (tick_emit) begin
            n_s1v = 1'b1;
        end else if (en_out) begin
            n_s1v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else begin
            r_s1v <= n_s1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_emit) begin
            r_s1_data <= emit_data;
            r_s1_last <= emit_last;
            r_s1_bit  <= r_bit;
        end
    end

    // Duty select from the fetched color bit
    assign duty = !r_s1_data ? 8'd0 : (color[r_s1_bit] ? r_duty_one : r_duty_zero);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_s1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s1v) begin
            r_od.duty <= duty;
            r_od.last <= r_s1_last;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    // Checks
    a_last_is_reset_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.last) |-> (o_out.data.duty == 8'd0))
        else $error("last slot carries nonzero duty");

    a_ready_low_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1v && r_ov))
        else $error("input stalled with a free stage");

    a_start_enters_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_in.data.kind == KIND_START)) |=> (r_phase == PH_DATA && r_bit == BIT_TOP))
        else $error("start did not restart the frame");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_emit && emit_last) |=> (r_phase == PH_IDLE))
        else $error("frame still active after last slot");

endmodule

[tb/tb_addressable_led_frame_encoder_core.sv]
// Self-checking bench for addressable_led_frame_encoder_core: directed rows, then random pixel
// writes, fills, starts and ticks, each result checked against a pinned slot or the in-bench predictor.
// Depends on alfe_pkg, alfe_ifs and the encoder RTL.
module tb_addressable_led_frame_encoder_core;
    import alfe_pkg::*;

    localparam int NPIX        = DEFAULT_PIXEL_COUNT;
    localparam int DATA_SLOTS  = BITS_PER_PIXEL * NPIX;
    localparam int LATENCY     = 2;
    localparam int PHASE_ITEMS = 160;
    localparam int NUM_PHASES  = 6;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        t_kind      kind;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         pinned;
        logic [7:0] duty;
        logic       last;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    alfe_in_if  in_ch ();
    alfe_out_if out_ch ();

    addressable_led_frame_encoder_core #(.PIXEL_COUNT(NPIX)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: pixel colors (green, red, blue), frame position, registers
    logic [23:0] pixel_colors [NPIX];
    int          next_slot;
    bit          frame_on;
    logic [7:0]  duty_one_cfg;
    logic [7:0]  duty_zero_cfg;
    logic [7:0]  latch_cfg;

    t_out_item pending_slots [$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        gap_odds;
    int        stall_odds;
    int        stall_left = 0;

    // Directed rows, reset register values; pinned rows carry a hand-computed slot
    t_row directed_rows [0:17] = '{
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0,  1'b0}, // idle tick
        '{KIND_WRITE_PIXEL, 8'd0,   8'h00, 8'hFF, 8'h00, 1'b0, 8'd0,  1'b0},
        '{KIND_WRITE_PIXEL, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'd0,  1'b0}, // out of range
        '{KIND_WRITE_PIXEL, 8'd8,   8'hFF, 8'hFF, 8'hFF, 1'b0, 8'd0,  1'b0}, // first bad index
        '{KIND_START,       8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0,  1'b0},
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 8'd67, 1'b0},
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 8'd67, 1'b0},
        '{KIND_WRITE_ALL,   8'd0,   8'hFF, 8'h00, 8'hAA, 1'b0, 8'd0,  1'b0}, // write mid-frame
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 8'd33, 1'b0},
        '{KIND_START,       8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0,  1'b0}, // restart
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 8'd33, 1'b0},
        '{KIND_WRITE_ALL,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0,  1'b0}, // clear
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 8'd33, 1'b0},
        '{KIND_WRITE_PIXEL, 8'd7,   8'h55, 8'hAA, 8'hFF, 1'b0, 8'd0,  1'b0}, // top pixel
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 8'd33, 1'b0},
        '{KIND_WRITE_PIXEL, 8'd0,   8'hFF, 8'hFF, 8'hFF, 1'b0, 8'd0,  1'b0},
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 8'd67, 1'b0},
        '{KIND_TICK,        8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 8'd67, 1'b0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("addressable_led_frame_encoder_core test failed");
            $finish;
        end
    end

    // Result side: ready with random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Result checker: oldest expected slot first
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_slots.size() == 0) begin
                $error("unexpected slot: duty %0d last %0d", out_ch.data.duty, out_ch.data.last);
                fail_count++;
            end else begin
                want = pending_slots.pop_front();
                if (out_ch.data.duty !== want.duty) begin
                    $error("duty: expected %0d, got %0d", want.duty, out_ch.data.duty);
                    fail_count++;
                end
                if (out_ch.data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_ch.data.last);
                    fail_count++;
                end
            end
        end
    end

    // Slot predictor: applies one item, returns the slot it emits, if any
    function automatic void encode_item(input t_in_item it, output bit has_slot,
                                        output t_out_item slot);
        int          s;
        int          latch_n;
        int          bit_pos;
        logic [23:0] color;
        has_slot = 1'b0;
        slot     = '0;
        case (t_kind'(it.kind))
            KIND_WRITE_PIXEL: begin
                if (int'(it.pixel_index) < NPIX)
                    pixel_colors[int'(it.pixel_index)] = {it.green, it.red, it.blue};
            end
            KIND_WRITE_ALL: begin
                for (int i = 0; i < NPIX; i++) pixel_colors[i] = {it.green, it.red, it.blue};
            end
            KIND_START: begin
                next_slot = 0;
                frame_on  = 1'b1;
            end
            KIND_TICK: begin
                if (frame_on) begin
                    // a zero latch count still ends the frame with one reset slot
                    latch_n = (latch_cfg == 8'd0) ? 1 : int'(latch_cfg);
                    s = next_slot;
                    if (s < DATA_SLOTS) begin
                        color    = pixel_colors[s / BITS_PER_PIXEL];
                        bit_pos  = BITS_PER_PIXEL - 1 - (s % BITS_PER_PIXEL);
                        slot.duty = color[bit_pos] ? duty_one_cfg : duty_zero_cfg;
                    end else begin
                        slot.duty = 8'd0;
                        slot.last = (s + 1 >= DATA_SLOTS + latch_n);
                    end
                    if (slot.last) begin
                        frame_on  = 1'b0;
                        next_slot = 0;
                    end else begin
                        next_slot = s + 1;
                    end
                    has_slot = 1'b1;
                end
            end
        endcase
    endfunction

    // Drives one item, waits for acceptance, then records what it should emit
    task automatic push_item(input t_in_item it, input bit pinned, input t_out_item pinned_slot);
        bit        has_slot;
        t_out_item slot;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        encode_item(it, has_slot, slot);
        if (has_slot) pending_slots.push_back(pinned ? pinned_slot : slot);
    endtask

    function automatic logic [7:0] color_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly ticks through running frames; writes land mid-frame, rare restarts
    function automatic t_in_item random_item();
        t_in_item it;
        int       roll;
        it.pixel_index = 8'($urandom_range(0, 255));
        it.red   = color_byte();
        it.green = color_byte();
        it.blue  = color_byte();
        roll = $urandom_range(0, 999);
        if (!frame_on && $urandom_range(0, 3) != 0) begin
            it.kind = KIND_START;
        end else if (roll < 80) begin
            it.kind = KIND_WRITE_PIXEL;
            if ($urandom_range(0, 4) != 0) it.pixel_index = 8'($urandom_range(0, NPIX - 1));
        end else if (roll < 110) begin
            it.kind = KIND_WRITE_ALL;
            if ($urandom_range(0, 3) == 0) begin
                it.red   = 8'h00;
                it.green = 8'h00;
                it.blue  = 8'h00;
            end
        end else if (roll < 113) begin
            it.kind = KIND_START;
        end else begin
            it.kind = KIND_TICK;
        end
        return it;
    endfunction

    task automatic tick_item(output t_in_item it);
        it = '0;
        it.kind = KIND_TICK;
    endtask

    // Sender holds off until every expected slot is back
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_slots.size() != 0) @(posedge i_clk);
    endtask

    // Runs the current frame to its end and lets the pipeline empty
    task automatic settle_block();
        t_in_item it;
        tick_item(it);
        while (frame_on) push_item(it, 1'b0, '0);
        hold_until_drained();
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_DUTY_ONE:  duty_one_cfg  = value;
            CFG_DUTY_ZERO: duty_zero_cfg = value;
            CFG_LATCH:     latch_cfg     = value;
            default:       ;
        endcase
    endtask

    // Main sequence
    initial begin
        t_in_item  it;
        t_out_item ps;
        int        done;
        logic [7:0] one_val;
        logic [7:0] zero_val;
        logic [7:0] latch_val;

        gap_odds    = 6;
        stall_odds  = 6;
        for (int i = 0; i < NPIX; i++) pixel_colors[i] = '0;
        next_slot     = 0;
        frame_on      = 1'b0;
        duty_one_cfg  = RST_DUTY_ONE;
        duty_zero_cfg = RST_DUTY_ZERO;
        latch_cfg     = RST_LATCH;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_DUTY_ONE;
        i_cfg_data   <= 8'd0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        foreach (directed_rows[r]) begin
            it.kind        = directed_rows[r].kind;
            it.pixel_index = directed_rows[r].index;
            it.red         = directed_rows[r].red;
            it.green       = directed_rows[r].green;
            it.blue        = directed_rows[r].blue;
            ps.duty        = directed_rows[r].duty;
            ps.last        = directed_rows[r].last;
            push_item(it, directed_rows[r].pinned, ps);
        end

        // Random phases, each under its own register setting
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle_block();
            case (phase)
                0: begin
                    one_val = RST_DUTY_ONE; zero_val = RST_DUTY_ZERO; latch_val = RST_LATCH;
                end
                1: begin
                    one_val = 8'd255; zero_val = 8'd0; latch_val = 8'd1;
                end
                2: begin
                    one_val = 8'd0; zero_val = 8'd255; latch_val = 8'd255;
                end
                3: begin
                    one_val = 8'hAA; zero_val = 8'h55; latch_val = 8'd0;
                end
                default: begin
                    one_val   = 8'($urandom_range(0, 255));
                    zero_val  = 8'($urandom_range(0, 255));
                    latch_val = 8'($urandom_range(0, 255));
                end
            endcase
            if (phase > 0) begin
                write_reg(CFG_DUTY_ONE, one_val);
                write_reg(CFG_DUTY_ZERO, zero_val);
                write_reg(CFG_LATCH, latch_val);
                i_cfg_we <= 1'b0;
            end
            gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
            stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);

            done = 0;
            while (done < PHASE_ITEMS) begin
                // the tail of the run goes without input gaps or output stalls
                if (phase == NUM_PHASES - 1 && done >= PHASE_ITEMS / 2) begin
                    gap_odds   = 0;
                    stall_odds = 0;
                end
                if ((phase == 2 && done == 80) || $urandom_range(0, 299) == 0)
                    hold_until_drained();
                it = random_item();
                if (!(t_kind'(it.kind) == KIND_TICK && !frame_on)) done++;
                push_item(it, 1'b0, '0);
            end
        end

        // Wind down
        in_ch.valid <= 1'b0;
        while (pending_slots.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("addressable_led_frame_encoder_core test passed");
        end else begin
            $display("addressable_led_frame_encoder_core test failed");
        end
        $finish;
    end

endmodule
